### rtl/core/seltab_pkg.sv
// Package for the sorted error log table: sizes, request and status codes,
// entry layout and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package seltab_pkg;
  localparam int DefTableDepth = 32;
  localparam int LetterW   = 5;
  localparam int NumberW   = 14;
  localparam int PrioW     = 10;
  localparam int EntryW    = LetterW + NumberW + PrioW + 1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_PURGE  = 2'd1;
  localparam logic [1:0] REQ_KEEP   = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_CRIT_LAST = 1'b1;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic [NumberW-1:0] number;
    logic [PrioW-1:0]   prio;
    logic               critical;
  } entry_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic start;     // latch request, reset scan pointers
    logic step;      // process one entry in the current pass
    logic pass2;     // second pass of keep or insert shift
    logic finish;    // load the result register
  } seltab_cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic done;      // current pass reached its end
    logic single;    // request needs no table walk
  } seltab_sts_t;
endpackage
`default_nettype wire

### rtl/core/seltab_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module seltab_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/seltab_ctrl.sv
// Controller state machine for the sorted error log table.
// Depends on seltab_pkg.
`default_nettype none
module seltab_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_fire,
  input  wire                      out_free,
  input  wire seltab_pkg::seltab_sts_t sts,
  output seltab_pkg::seltab_cmd_t  cmd,
  output logic                     busy
);
  import seltab_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK1 = 5'b00010,
    S_WALK2 = 5'b00100,
    S_DONE  = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_next = S_WALK1;
        end
      end
      S_WALK1: begin
        if (sts.single || sts.done) begin
          state_next = S_WALK2;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WALK2: begin
        cmd.pass2 = 1'b1;
        if (sts.single || sts.done) begin
          state_next = S_WAIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

### rtl/core/seltab_dp.sv
// Datapath for the sorted error log table: entry RAM, scan pointers,
// fill and critical counters, and the result register.
// Depends on seltab_pkg and seltab_ram.
`default_nettype none
module seltab_dp #(
  parameter int TableDepth = seltab_pkg::DefTableDepth
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire seltab_pkg::seltab_cmd_t cmd,
  output seltab_pkg::seltab_sts_t  sts,
  input  wire [1:0]                req_type,
  input  wire [4:0]                new_letter,
  input  wire [13:0]               new_number,
  input  wire [9:0]                new_priority,
  input  wire [4:0]                read_index,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire [9:0]                cfg_data,
  output logic [1:0]               res_status,
  output logic [5:0]               res_count,
  output logic [5:0]               res_crit,
  output logic [5:0]               res_noncrit,
  output seltab_pkg::entry_t       res_entry
);
  import seltab_pkg::*;

  localparam int AW = $clog2(TableDepth);
  localparam int CW = $clog2(TableDepth + 1);

  // Configuration registers.
  logic [9:0] purge_threshold;
  logic [4:0] crit_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      purge_threshold <= 10'd300;
      crit_last       <= 5'd4;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESHOLD) purge_threshold <= cfg_data;
      else                            crit_last <= cfg_data[4:0];
    end
  end

  // Latched request.
  logic [1:0] req;
  entry_t     newe;
  logic [4:0] ridx;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req  <= req_type;
      newe <= '{new_letter, new_number, new_priority,
                (new_letter <= crit_last)};
      ridx <= read_index;
    end
  end

  // Table RAM. The walk reads one entry a cycle: address issued at
  // pointer rp, data valid the next cycle, tagged with rv/rpos.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  seltab_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [CW-1:0] fill, crit_cnt;
  logic [CW-1:0] rp;      // next position to issue a read for
  logic [CW-1:0] dst;     // compaction write pointer / insert position
  logic          rv;      // rdata valid
  logic [CW-1:0] rpos;    // position of rdata
  logic [CW-1:0] new_crit;
  logic          found, ins_found, keep_done;
  logic [CW-1:0] best;
  logic [PrioW-1:0] best_prio;
  logic [1:0]    status;
  logic          walk_end;
  logic          in_range;

  assign in_range = ({{(CW > 5 ? CW-5 : 0){1'b0}}, ridx} < fill) &&
                    (32'(ridx) < 32'(TableDepth));
  assign walk_end = (rp >= fill) && !rv;

  // Requests that need no table walk: read and full insert; purge and keep walk.
  // Insert: pass 1 finds the position, pass 2 shifts from the top down.
  always_comb begin
    sts.single = 1'b0;
    if (req == REQ_READ) sts.single = rv || cmd.pass2 ? 1'b1 : 1'b0;
    if (req == REQ_INSERT && fill >= CW'(TableDepth)) sts.single = 1'b1;
    if (req == REQ_KEEP && cmd.pass2 && !found) sts.single = 1'b1;
    sts.done = walk_end;
    if (req == REQ_INSERT && !cmd.pass2) sts.done = ins_found || walk_end;
    if (req == REQ_INSERT && cmd.pass2) sts.done = (rp == dst) && !rv;
  end

  // Read address: up-walk, a down-walk for the insert shift, or the read index.
  always_comb begin
    raddr = rp[AW-1:0];
    if (req == REQ_INSERT && cmd.pass2) raddr = AW'(rp - 1'b1);
    if (req == REQ_READ) raddr = AW'(ridx);
  end

  // Write port decode.
  always_comb begin
    we = 1'b0; waddr = dst[AW-1:0]; wdata = rdata;
    if (rv && req == REQ_PURGE && cmd.pass2 == 1'b0) begin
      we = rdata.prio >= purge_threshold;
    end
    if (rv && req == REQ_KEEP && cmd.pass2) begin
      we = rdata.critical || rpos == best;
    end
    if (req == REQ_INSERT && cmd.pass2 && rv) begin
      we = 1'b1; waddr = AW'(rpos + 1'b1);
    end
    if (req == REQ_INSERT && cmd.pass2 && (rp == dst) && !rv &&
        fill < CW'(TableDepth)) begin
      we = 1'b1; waddr = dst[AW-1:0]; wdata = newe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; crit_cnt <= '0; rv <= 1'b0; dst <= '0; new_crit <= '0;
    end else if (cmd.start) begin
      rp <= '0; dst <= '0; rv <= 1'b0; found <= 1'b0; ins_found <= 1'b0;
      keep_done <= 1'b0; new_crit <= '0;
      best <= '0; best_prio <= '0; status <= ST_OK;
    end else begin
      rv <= 1'b0;
      if (cmd.step && !(req == REQ_INSERT && cmd.pass2) && rp < fill) begin
        rv <= 1'b1; rpos <= rp; rp <= rp + 1'b1;
      end
      if (cmd.step && req == REQ_INSERT && cmd.pass2 && rp != dst) begin
        rv <= 1'b1; rpos <= rp - 1'b1; rp <= rp - 1'b1;
      end
      // Pass 1 data handling.
      if (rv && !cmd.pass2) begin
        case (req)
          REQ_INSERT: begin
            if (newe.letter < rdata.letter ||
                (newe.letter == rdata.letter && newe.prio > rdata.prio)) begin
              ins_found <= 1'b1; dst <= rpos; rp <= fill; rv <= 1'b0;
            end else begin
              dst <= rpos + 1'b1;
            end
          end
          REQ_PURGE: begin
            if (rdata.prio >= purge_threshold) begin
              dst <= dst + 1'b1;
              new_crit <= new_crit + CW'(rdata.critical);
            end
          end
          REQ_KEEP: begin
            if (!rdata.critical && (!found || rdata.prio > best_prio)) begin
              found <= 1'b1; best <= rpos; best_prio <= rdata.prio;
            end
          end
          default: ;
        endcase
      end
      // End of pass 1 transitions.
      if (!cmd.pass2 && !cmd.step && !cmd.finish) begin
        if (req == REQ_INSERT && !ins_found) begin
          dst <= fill; rp <= fill;
        end
        if (req == REQ_PURGE) begin
          fill <= dst; crit_cnt <= new_crit;
        end
        if (req == REQ_KEEP) begin
          rp <= '0; dst <= '0;
        end
        if (req == REQ_INSERT && fill >= CW'(TableDepth)) status <= ST_FULL;
        if (req == REQ_READ) begin
          rv <= 1'b1;
          if (!in_range) status <= ST_RANGE;
        end
      end
      // Pass 2: keep compaction.
      if (rv && cmd.pass2 && req == REQ_KEEP &&
          (rdata.critical || rpos == best)) dst <= dst + 1'b1;
      if (cmd.pass2 && req == REQ_KEEP && found && walk_end && !keep_done) begin
        keep_done <= 1'b1; fill <= dst; crit_cnt <= crit_cnt;
      end
      // Pass 2: insert final write.
      if (cmd.pass2 && req == REQ_INSERT && rp == dst && !rv &&
          fill < CW'(TableDepth) && !keep_done) begin
        keep_done <= 1'b1; fill <= fill + 1'b1;
        crit_cnt <= crit_cnt + CW'(newe.critical);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status  <= status;
      res_count   <= 6'(fill);
      res_crit    <= 6'(crit_cnt);
      res_noncrit <= 6'(fill - crit_cnt);
      res_entry   <= (req == REQ_READ && status == ST_OK) ? rdata : '0;
    end
  end
endmodule
`default_nettype wire

### rtl/core/sorted_error_log_table.sv
// Sorted error log table, top level: stream handshake, controller, datapath.
// Purge, keep and insert requests walk the entry RAM one entry per cycle.
// Throughput: one request at a time; next beat taken after the result leaves.
// Reset (synchronous rst) empties the table and restores config defaults.
`default_nettype none
module sorted_error_log_table #(
  parameter int TABLE_DEPTH = seltab_pkg::DefTableDepth
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // req_type[1:0], new_letter[6:2], new_number[20:7], new_priority[30:21],
  // read_index[35:31], zero fill
  input  wire  [39:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // status[1:0], entry_count[7:2], critical_count[13:8],
  // noncritical_count[19:14], entry_letter[24:20], entry_number[38:25],
  // entry_priority[48:39], entry_critical[49], zero fill
  output logic [55:0] m_tdata,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [9:0]  cfg_data
);
  import seltab_pkg::*;

  seltab_cmd_t cmd;
  seltab_sts_t sts;
  logic        busy, in_fire;
  logic [1:0]  res_status;
  logic [5:0]  res_count, res_crit, res_noncrit;
  entry_t      res_entry;

  assign s_tready = !busy && !m_tvalid;
  assign in_fire  = s_tvalid && s_tready;

  seltab_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!m_tvalid),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  seltab_dp #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_type(s_tdata[1:0]), .new_letter(s_tdata[6:2]),
    .new_number(s_tdata[20:7]), .new_priority(s_tdata[30:21]),
    .read_index(s_tdata[35:31]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_status(res_status), .res_count(res_count), .res_crit(res_crit),
    .res_noncrit(res_noncrit), .res_entry(res_entry)
  );

  // Output beat valid flag.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.finish) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {6'd0, res_entry.critical, res_entry.prio,
                    res_entry.number, res_entry.letter, res_noncrit,
                    res_crit, res_count, res_status};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("input taken while busy");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !m_tvalid) else $error("result overwritten");
  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:8] + m_tdata[19:14] == m_tdata[7:2]))
    else $error("counts disagree");
endmodule
`default_nettype wire

### verif/tb_sorted_error_log_table.sv
// Testbench for the sorted error log table: drives request beats, predicts
// every response with a behavioral table model and compares field by field.
// Depends on seltab_pkg and sorted_error_log_table.
module tb_sorted_error_log_table;
  import seltab_pkg::*;

  localparam int Depth = 32;

  typedef struct packed {
    logic [4:0]  letter;
    logic [13:0] number;
    logic [9:0]  prio;
    logic        crit;
  } log_rec_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  total;
    logic [5:0]  crit_n;
    logic [5:0]  noncrit_n;
    logic [4:0]  letter;
    logic [13:0] number;
    logic [9:0]  prio;
    logic        crit;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_THRESHOLD;
  logic [9:0] cfg_data = '0;

  // Testbench copy of the table and its registers.
  log_rec_t tbl [Depth];
  int unsigned fill;
  logic [9:0] thresh_q;
  logic [4:0] crit_last_q;

  logic [39:0] pending_reqs [$];
  resp_t expected_resps [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int errors = 0;
  bit sent_all = 1'b0;

  sorted_error_log_table #(.TABLE_DEPTH(Depth)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [39:0] pack_req(logic [1:0] kind, logic [4:0] letter,
                                           logic [13:0] number, logic [9:0] prio,
                                           logic [4:0] idx);
    return {4'b0, idx, prio, number, letter, kind};
  endfunction

  // Applies one request to the table copy and returns the expected response.
  function automatic resp_t apply_request(logic [39:0] beat);
    logic [1:0] kind;
    logic [4:0] letter;
    logic [9:0] prio;
    logic [4:0] idx;
    int unsigned pos, dst, best, ncrit;
    bit found;
    resp_t r;
    kind = beat[1:0];
    letter = beat[6:2];
    prio = beat[30:21];
    idx = beat[35:31];
    r = '0;
    case (kind)
      REQ_INSERT: begin
        if (fill >= Depth) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill && !(letter < tbl[pos].letter ||
                 (letter == tbl[pos].letter && prio > tbl[pos].prio)))
            pos++;
          for (int i = fill; i > pos; i--) tbl[i] = tbl[i-1];
          tbl[pos] = {letter, beat[20:7], prio, letter <= crit_last_q};
          fill++;
        end
      end
      REQ_PURGE: begin
        dst = 0;
        for (int i = 0; i < fill; i++)
          if (tbl[i].prio >= thresh_q) tbl[dst++] = tbl[i];
        fill = dst;
      end
      REQ_KEEP: begin
        found = 0;
        best = 0;
        for (int i = 0; i < fill; i++)
          if (!tbl[i].crit && (!found || tbl[i].prio > tbl[best].prio)) begin
            found = 1;
            best = i;
          end
        if (found) begin
          dst = 0;
          for (int i = 0; i < fill; i++)
            if (tbl[i].crit || i == best) tbl[dst++] = tbl[i];
          fill = dst;
        end
      end
      default: begin
        if (idx < fill) begin
          r.letter = tbl[idx].letter;
          r.number = tbl[idx].number;
          r.prio = tbl[idx].prio;
          r.crit = tbl[idx].crit;
        end else begin
          r.status = ST_RANGE;
        end
      end
    endcase
    ncrit = 0;
    for (int i = 0; i < fill; i++) ncrit += tbl[i].crit;
    r.total = 6'(fill);
    r.crit_n = 6'(ncrit);
    r.noncrit_n = 6'(fill - ncrit);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Driver: presents queued request beats, idling at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) expected_resps.push_back(apply_request(s_tdata));
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_reqs.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each response beat against the oldest prediction.
  always @(posedge clk) begin
    resp_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[7:2], m_tdata[13:8], m_tdata[19:14],
               m_tdata[24:20], m_tdata[38:25], m_tdata[48:39], m_tdata[49]};
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected response", 1, 0);
        end else begin
          want = expected_resps.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.total != want.total) report_mismatch("entry_count", got.total, want.total);
          if (got.crit_n != want.crit_n)
            report_mismatch("critical_count", got.crit_n, want.crit_n);
          if (got.noncrit_n != want.noncrit_n)
            report_mismatch("noncritical_count", got.noncrit_n, want.noncrit_n);
          if (got.letter != want.letter) report_mismatch("entry_letter", got.letter, want.letter);
          if (got.number != want.number) report_mismatch("entry_number", got.number, want.number);
          if (got.prio != want.prio)
            report_mismatch("entry_priority", got.prio, want.prio);
          if (got.crit != want.crit)
            report_mismatch("entry_critical", got.crit, want.crit);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Waits until every queued request is accepted and answered.
  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (2 * Depth + 10) @(posedge clk);
  endtask

  // One register write, after which the write port is left quiet.
  task automatic write_reg(logic idx, logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD) thresh_q = value;
    else crit_last_q = value[4:0];
    @(posedge clk);
  endtask

  function automatic logic [39:0] random_req();
    int unsigned pick;
    logic [1:0] kind;
    pick = $urandom_range(99);
    kind = pick < 55 ? REQ_INSERT : pick < 62 ? REQ_PURGE : pick < 67 ? REQ_KEEP : REQ_READ;
    return pack_req(kind,
                    $urandom_range(9) == 0 ? 5'($urandom) : 5'($urandom_range(25)),
                    $urandom_range(3) == 0 ? 14'($urandom) : 14'($urandom_range(9999)),
                    $urandom_range(7) == 0 ? 10'($urandom) : 10'($urandom_range(1000)),
                    5'($urandom));
  endfunction

  initial begin
    fill = 0;
    thresh_q = 10'd300;
    crit_last_q = 5'd4;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, ties, reads out of range, keep with none.
    pending_reqs.push_back(pack_req(REQ_KEEP, 0, 0, 0, 0));
    pending_reqs.push_back(pack_req(REQ_READ, 0, 0, 0, 0));
    pending_reqs.push_back(pack_req(REQ_INSERT, 0, 0, 0, 0));
    pending_reqs.push_back(pack_req(REQ_INSERT, 25, 9999, 1000, 0));
    pending_reqs.push_back(pack_req(REQ_INSERT, 31, 14'h3fff, 10'h3ff, 31));
    pending_reqs.push_back(pack_req(REQ_INSERT, 5, 1, 500, 0));
    pending_reqs.push_back(pack_req(REQ_INSERT, 5, 2, 500, 0));
    pending_reqs.push_back(pack_req(REQ_INSERT, 5, 3, 800, 0));
    pending_reqs.push_back(pack_req(REQ_INSERT, 4, 4, 100, 0));
    for (int i = 0; i < 7; i++) pending_reqs.push_back(pack_req(REQ_READ, 0, 0, 0, 5'(i)));
    pending_reqs.push_back(pack_req(REQ_READ, 0, 0, 0, 31));
    pending_reqs.push_back(pack_req(REQ_KEEP, 0, 0, 0, 0));
    pending_reqs.push_back(pack_req(REQ_PURGE, 0, 0, 0, 0));
    for (int i = 0; i < 3; i++) pending_reqs.push_back(pack_req(REQ_READ, 0, 0, 0, 5'(i)));
    drain();

    // Fill the table past full, then purge every entry below priority 1000.
    write_reg(CFG_CRIT_LAST, 10'd25);
    write_reg(CFG_THRESHOLD, 10'd1000);
    for (int i = 0; i < 34; i++)
      pending_reqs.push_back(pack_req(REQ_INSERT, 5'($urandom_range(3)),
                                      14'($urandom_range(9999)),
                                      10'($urandom_range(1000)), 0));
    pending_reqs.push_back(pack_req(REQ_READ, 0, 0, 0, 31));
    pending_reqs.push_back(pack_req(REQ_PURGE, 0, 0, 0, 0));
    drain();

    // Random phases under three idling patterns and several register settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 28; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(CFG_THRESHOLD, phase == 0 ? 10'd0 : phase == 5 ? 10'h3ff
                                 : 10'($urandom_range(1000)));
      write_reg(CFG_CRIT_LAST, phase == 0 ? 10'd0 : phase == 5 ? 10'd31
                                 : 10'($urandom_range(25)));
      for (int i = 0; i < 57; i++) pending_reqs.push_back(random_req());
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
